// ===== rtl/core/jda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jda_pkg;

    localparam int NUM_STICKS_DEF = 4;
    localparam int MAX_RESULTS    = 4;

    localparam int THR_W   = 7;
    localparam int TIME_W  = 16;
    localparam int TIMER_W = 18;
    localparam int DIR_W   = 3;
    localparam int CNT_W   = 3;

    localparam logic [THR_W-1:0]  THRESHOLD_RST = 7'd60;
    localparam logic [TIME_W-1:0] INIT_DELAY_RST = 16'd500;
    localparam logic [TIME_W-1:0] REPEAT_RST     = 16'd50;

    // held direction codes, nav_direction is code minus one
    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

    localparam logic [1:0] REG_AXIS_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_INITIAL_DELAY  = 2'd1;
    localparam logic [1:0] REG_REPEAT_PERIOD  = 2'd2;

    localparam logic CMD_AXIS = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic AXIS_X = 1'b0;

    // classified word handed from front to back
    typedef struct packed {
        logic              is_tick;
        logic [1:0]        stick_id;
        logic              axis_select;
        logic [DIR_W-1:0]  new_dir;
        logic [TIME_W-1:0] elapsed_ms;
    } t_jda_cmd;

    typedef struct packed {
        logic             busy;
        logic             walking;
        logic [CNT_W-1:0] fired;
    } t_jda_stat;

endpackage

`default_nettype wire

// ===== rtl/core/jda_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jda_front (
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_command,
    input  wire logic [1:0]                 i_stick_id,
    input  wire logic                       i_axis_select,
    input  wire logic signed [7:0]          i_position,
    input  wire logic [15:0]                i_elapsed_ms,
    input  wire logic [jda_pkg::THR_W-1:0]  i_axis_threshold,
    output logic                            o_push,
    output jda_pkg::t_jda_cmd               o_cmd,
    input  wire logic                       i_q_ready
);

    logic signed [8:0] pos_x;
    logic signed [8:0] thr_x;
    logic signed [8:0] thr_n;
    logic              is_neg;
    logic              is_pos;
    logic [jda_pkg::DIR_W-1:0] dir;

    assign pos_x = {i_position[7], i_position};
    assign thr_x = $signed({2'b00, i_axis_threshold});
    assign thr_n = -thr_x;
    assign is_neg = pos_x < thr_n;
    assign is_pos = pos_x > thr_x;

    always_comb begin
        if (i_axis_select == jda_pkg::AXIS_X) begin
            dir = is_neg ? jda_pkg::DIR_LEFT : (is_pos ? jda_pkg::DIR_RIGHT : jda_pkg::DIR_NONE);
        end else begin
            dir = is_neg ? jda_pkg::DIR_UP : (is_pos ? jda_pkg::DIR_DOWN : jda_pkg::DIR_NONE);
        end
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid & i_q_ready;

    always_comb begin
        o_cmd.is_tick     = (i_command == jda_pkg::CMD_TICK);
        o_cmd.stick_id    = i_stick_id;
        o_cmd.axis_select = i_axis_select;
        o_cmd.new_dir     = dir;
        o_cmd.elapsed_ms  = i_elapsed_ms;
    end

endmodule

`default_nettype wire

// ===== rtl/core/jda_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jda_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire jda_pkg::t_jda_cmd i_cmd,
    output logic                   o_ready,
    output logic                   o_valid,
    output jda_pkg::t_jda_cmd      o_cmd,
    input  wire logic              i_pop_ready,
    output logic [1:0]             o_level
);

    jda_pkg::t_jda_cmd r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_level = r_cnt;
    assign do_push = i_push & o_ready;
    assign do_pop  = o_valid & i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/jda_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jda_back #(
    parameter int NUM_STICKS = jda_pkg::NUM_STICKS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire jda_pkg::t_jda_cmd           i_cmd,
    output logic                             o_ready,
    input  wire logic [jda_pkg::TIME_W-1:0]  i_initial_delay,
    input  wire logic [jda_pkg::TIME_W-1:0]  i_repeat_period,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [2:0]                       o_player,
    output logic [1:0]                       o_nav_direction,
    output logic                             o_last,
    output jda_pkg::t_jda_stat               o_stat
);

    localparam int SW = (NUM_STICKS > 1) ? $clog2(NUM_STICKS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [jda_pkg::DIR_W-1:0]          r_held [NUM_STICKS];
    logic signed [jda_pkg::TIMER_W-1:0] r_time [NUM_STICKS];
    logic                               r_rep  [NUM_STICKS];

    logic [SW-1:0]               r_walk, n_walk;
    logic [jda_pkg::CNT_W-1:0]   r_count, n_count;
    logic [jda_pkg::TIME_W-1:0]  r_elapsed, n_elapsed;
    logic                        r_pend_valid, n_pend_valid;
    logic [2:0]                  r_pend_player, n_pend_player;
    logic [1:0]                  r_pend_dir, n_pend_dir;
    logic                        r_out_valid;
    logic [2:0]                  r_out_player;
    logic [1:0]                  r_out_dir;
    logic                        r_out_last;

    logic [SW-1:0]                      idx;
    logic [jda_pkg::DIR_W-1:0]          cur_dir;
    logic signed [jda_pkg::TIMER_W-1:0] cur_time;
    logic                               cur_rep;
    logic                               out_free;
    logic                               due;
    logic                               fire;
    logic                               stick_ok;
    logic                               axis_ok;
    logic [4:0]                         walk_ext;
    logic signed [jda_pkg::TIMER_W-1:0] time_dec;

    logic                               wr_held;
    logic [jda_pkg::DIR_W-1:0]          wr_held_val;
    logic                               wr_timer;
    logic signed [jda_pkg::TIMER_W-1:0] wr_time_val;
    logic                               wr_rep_val;
    logic                               ld_out;
    logic [2:0]                         ld_player;
    logic [1:0]                         ld_dir;
    logic                               ld_last;

    assign idx      = (r_state == ST_IDLE) ? SW'(i_cmd.stick_id) : r_walk;
    assign cur_dir  = r_held[idx];
    assign cur_time = r_time[idx];
    assign cur_rep  = r_rep[idx];
    assign out_free = !r_out_valid || i_ready;
    assign walk_ext = 5'(r_walk);
    // timer at or below zero means due
    assign due      = (cur_dir != jda_pkg::DIR_NONE)
                      && (cur_time[jda_pkg::TIMER_W-1] || (cur_time == '0));
    assign fire     = due && (r_count < jda_pkg::CNT_W'(jda_pkg::MAX_RESULTS));
    assign time_dec = cur_time - $signed({2'b00, r_elapsed});
    assign stick_ok = ({3'b000, i_cmd.stick_id} < 5'(NUM_STICKS));

    always_comb begin
        if (i_cmd.axis_select == jda_pkg::AXIS_X) begin
            axis_ok = (cur_dir == jda_pkg::DIR_NONE) || (cur_dir == jda_pkg::DIR_LEFT)
                      || (cur_dir == jda_pkg::DIR_RIGHT);
        end else begin
            axis_ok = (cur_dir == jda_pkg::DIR_NONE) || (cur_dir == jda_pkg::DIR_UP)
                      || (cur_dir == jda_pkg::DIR_DOWN);
        end
    end

    always_comb begin
        n_state       = r_state;
        n_walk        = r_walk;
        n_count       = r_count;
        n_elapsed     = r_elapsed;
        n_pend_valid  = r_pend_valid;
        n_pend_player = r_pend_player;
        n_pend_dir    = r_pend_dir;
        o_ready       = 1'b0;
        wr_held       = 1'b0;
        wr_held_val   = i_cmd.new_dir;
        wr_timer      = 1'b0;
        wr_time_val   = time_dec;
        wr_rep_val    = cur_rep;
        ld_out        = 1'b0;
        ld_player     = r_pend_player;
        ld_dir        = r_pend_dir;
        ld_last       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_cmd.is_tick) begin
                        n_state   = ST_WALK;
                        n_walk    = '0;
                        n_count   = '0;
                        n_elapsed = i_cmd.elapsed_ms;
                    end else if (stick_ok && axis_ok) begin
                        wr_held = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                // a new event bumps the pending one to the output register
                if (!(fire && r_pend_valid && !out_free)) begin
                    if (cur_dir == jda_pkg::DIR_NONE) begin
                        wr_timer    = 1'b1;
                        wr_time_val = '0;
                        wr_rep_val  = 1'b0;
                    end else if (due) begin
                        if (fire) begin
                            wr_timer      = 1'b1;
                            wr_time_val   = cur_rep ? $signed({2'b00, i_repeat_period})
                                                    : $signed({2'b00, i_initial_delay});
                            wr_rep_val    = 1'b1;
                            n_count       = r_count + jda_pkg::CNT_W'(1);
                            n_pend_valid  = 1'b1;
                            n_pend_player = 3'(walk_ext + 5'd1);
                            n_pend_dir    = 2'(cur_dir - 3'd1);
                            ld_out        = r_pend_valid;
                        end
                    end else begin
                        wr_timer = 1'b1;
                    end
                    if (r_walk == SW'(NUM_STICKS - 1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_walk = r_walk + SW'(1);
                    end
                end
            end
            ST_DONE: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    ld_out       = 1'b1;
                    ld_last      = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STICKS; k++) begin
                r_held[k] <= jda_pkg::DIR_NONE;
                r_time[k] <= '0;
                r_rep[k]  <= 1'b0;
            end
        end else begin
            if (wr_held) begin
                r_held[idx] <= wr_held_val;
            end
            if (wr_timer) begin
                r_time[idx] <= wr_time_val;
                r_rep[idx]  <= wr_rep_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_walk       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_walk       <= n_walk;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_elapsed     <= n_elapsed;
        r_pend_player <= n_pend_player;
        r_pend_dir    <= n_pend_dir;
        if (ld_out) begin
            r_out_player <= ld_player;
            r_out_dir    <= ld_dir;
            r_out_last   <= ld_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_player        = r_out_player;
    assign o_nav_direction = r_out_dir;
    assign o_last          = r_out_last;

    always_comb begin
        o_stat.busy    = (r_state != ST_IDLE);
        o_stat.walking = (r_state == ST_WALK);
        o_stat.fired   = r_count;
    end

endmodule

`default_nettype wire

// ===== rtl/core/joystick_direction_autorepeat.sv =====
// An accepted axis word waits in the two-entry queue and updates the stick state
// when the idle back end takes it; a tick is taken the same way, walked stick by
// stick, and its events pass through the pending and output registers. A tick walks
// the sticks one per cycle while the output does not stall.
// Reset (synchronous, active low) sets every stick to no direction, clears
// timers, repeat flags and the queue, and loads the default settings.
`timescale 1ns / 1ps
`default_nettype none

module joystick_direction_autorepeat #(
    parameter int NUM_STICKS = jda_pkg::NUM_STICKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [1:0] stick_id, [2] axis_select, [10:3] position, [26:11] elapsed_ms
    input  wire logic [31:0] i_s_axis_tdata,
    // [0] command
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [2:0] player, [4:3] nav_direction
    output logic [7:0]       o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [jda_pkg::THR_W-1:0]  r_axis_threshold;
    logic [jda_pkg::TIME_W-1:0] r_initial_delay;
    logic [jda_pkg::TIME_W-1:0] r_repeat_period;

    logic               f_push;
    jda_pkg::t_jda_cmd  f_cmd;
    logic               q_ready;
    logic               q_valid;
    jda_pkg::t_jda_cmd  q_cmd;
    logic [1:0]         q_level;
    logic               b_ready;
    logic [2:0]         b_player;
    logic [1:0]         b_dir;
    jda_pkg::t_jda_stat b_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_threshold <= jda_pkg::THRESHOLD_RST;
            r_initial_delay  <= jda_pkg::INIT_DELAY_RST;
            r_repeat_period  <= jda_pkg::REPEAT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                jda_pkg::REG_AXIS_THRESHOLD: r_axis_threshold <= i_cfg_data[6:0];
                jda_pkg::REG_INITIAL_DELAY:  r_initial_delay  <= i_cfg_data;
                jda_pkg::REG_REPEAT_PERIOD:  r_repeat_period  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    jda_front u_front (
        .i_valid          (i_s_axis_tvalid),
        .o_ready          (o_s_axis_tready),
        .i_command        (i_s_axis_tuser),
        .i_stick_id       (i_s_axis_tdata[1:0]),
        .i_axis_select    (i_s_axis_tdata[2]),
        .i_position       ($signed(i_s_axis_tdata[10:3])),
        .i_elapsed_ms     (i_s_axis_tdata[26:11]),
        .i_axis_threshold (r_axis_threshold),
        .o_push           (f_push),
        .o_cmd            (f_cmd),
        .i_q_ready        (q_ready)
    );

    jda_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_push),
        .i_cmd       (f_cmd),
        .o_ready     (q_ready),
        .o_valid     (q_valid),
        .o_cmd       (q_cmd),
        .i_pop_ready (b_ready),
        .o_level     (q_level)
    );

    jda_back #(
        .NUM_STICKS (NUM_STICKS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_cmd           (q_cmd),
        .o_ready         (b_ready),
        .i_initial_delay (r_initial_delay),
        .i_repeat_period (r_repeat_period),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_player        (b_player),
        .o_nav_direction (b_dir),
        .o_last          (o_m_axis_tlast),
        .o_stat          (b_stat)
    );

    assign o_m_axis_tdata = {3'b000, b_dir, b_player};

    // no more than the result limit per tick
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stat.fired <= 3'(jda_pkg::MAX_RESULTS))
        else $error("tick fired more events than allowed");

    // back end takes nothing from the queue while a tick is in progress
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stat.busy |-> !b_ready)
        else $error("queue popped during tick walk");

    // a word that is not the last of its tick means the tick is still open
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> b_stat.busy)
        else $error("non-final word left without an open tick");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level != 2'd3)
        else $error("queue level out of range");

endmodule

`default_nettype wire

// ===== test/tb_joystick_direction_autorepeat.sv =====
`timescale 1ns / 1ps

module tb_joystick_direction_autorepeat;
    import jda_pkg::*;

    localparam int N_STICKS = NUM_STICKS_DEF;
    // back end walks the sticks one per cycle while the output does not stall; leave room for an axis word in flight
    localparam int SETTLE   = 4 * N_STICKS + 16;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  stick;
        logic        axis;
        logic [7:0]  pos;
        logic [15:0] elapsed;
    } stick_word_t;

    typedef struct packed {
        logic [2:0] player;
        logic [1:0] dir;
        logic       last;
    } nav_event_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    joystick_direction_autorepeat uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // settings as the block should hold them
    logic [THR_W-1:0]  cfg_thr;
    logic [TIME_W-1:0] cfg_init;
    logic [TIME_W-1:0] cfg_rep;

    // per-stick state
    logic [DIR_W-1:0] held_dir [N_STICKS];
    int               time_left [N_STICKS];
    bit               repeating [N_STICKS];

    stick_word_t pending_words [$];
    nav_event_t  expected_events [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  errors;
    int  axis_words;
    int  tick_words;
    int  events_checked;
    int  most_per_tick;
    bit  s_word_taken;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch @%0t: %s", $time, what);
    endtask

    function automatic logic [DIR_W-1:0] classify(input logic [7:0] pos,
                                                  input logic [DIR_W-1:0] neg_dir,
                                                  input logic [DIR_W-1:0] pos_dir);
        int p;
        int t;
        p = $signed(pos);
        t = cfg_thr;
        if (p < -t)
            return neg_dir;
        if (p > t)
            return pos_dir;
        return DIR_NONE;
    endfunction

    task automatic apply_stick_word(input stick_word_t w);
        nav_event_t       fired [$];
        nav_event_t       ev;
        logic [DIR_W-1:0] d;
        int               i;
        if (w.cmd == CMD_AXIS) begin
            axis_words++;
            d = held_dir[w.stick];
            if (w.axis == AXIS_X) begin
                if (d == DIR_NONE || d == DIR_LEFT || d == DIR_RIGHT)
                    held_dir[w.stick] = classify(w.pos, DIR_LEFT, DIR_RIGHT);
            end else if (d == DIR_NONE || d == DIR_UP || d == DIR_DOWN) begin
                held_dir[w.stick] = classify(w.pos, DIR_UP, DIR_DOWN);
            end
        end else begin
            tick_words++;
            for (i = 0; i < N_STICKS; i++) begin
                d = held_dir[i];
                if (d == DIR_NONE) begin
                    time_left[i] = 0;
                    repeating[i] = 1'b0;
                end else if (time_left[i] <= 0) begin
                    if (fired.size() < MAX_RESULTS) begin
                        ev.player = 3'(i + 1);
                        ev.dir    = 2'(d - 3'd1);
                        ev.last   = 1'b0;
                        fired.push_back(ev);
                        if (!repeating[i]) begin
                            time_left[i] = cfg_init;
                            repeating[i] = 1'b1;
                        end else begin
                            time_left[i] = cfg_rep;
                        end
                    end
                end else begin
                    time_left[i] = time_left[i] - int'(w.elapsed);
                end
            end
            for (i = 0; i < fired.size(); i++) begin
                ev      = fired[i];
                ev.last = (i == fired.size() - 1);
                expected_events.push_back(ev);
            end
            if (fired.size() > most_per_tick)
                most_per_tick = fired.size();
        end
    endtask

    // sender: one word per handshake, held until taken
    always @(negedge i_clk) begin : drive
        stick_word_t w;
        if (i_rst_n && (!i_s_axis_tvalid || s_word_taken)) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                i_s_axis_tdata  <= {5'b0, w.elapsed, w.pos, w.axis, w.stick};
                i_s_axis_tuser  <= w.cmd;
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : watch
        stick_word_t w;
        nav_event_t  want;
        s_word_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (s_word_taken) begin
            w.cmd     = i_s_axis_tuser;
            w.stick   = i_s_axis_tdata[1:0];
            w.axis    = i_s_axis_tdata[2];
            w.pos     = i_s_axis_tdata[10:3];
            w.elapsed = i_s_axis_tdata[26:11];
            apply_stick_word(w);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event word %h last %b",
                                          o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want = expected_events.pop_front();
                events_checked++;
                if (o_m_axis_tdata[2:0] !== want.player)
                    report_mismatch($sformatf("player %0d, want %0d",
                                              o_m_axis_tdata[2:0], want.player));
                if (o_m_axis_tdata[4:3] !== want.dir)
                    report_mismatch($sformatf("direction %0d, want %0d (player %0d)",
                                              o_m_axis_tdata[4:3], want.dir, want.player));
                if (o_m_axis_tlast !== want.last)
                    report_mismatch($sformatf("tlast %b, want %b (player %0d)",
                                              o_m_axis_tlast, want.last, want.player));
                if (o_m_axis_tdata[7:5] !== 3'b000)
                    report_mismatch($sformatf("padding bits %b", o_m_axis_tdata[7:5]));
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            REG_AXIS_THRESHOLD: cfg_thr  = val[THR_W-1:0];
            REG_INITIAL_DELAY:  cfg_init = val;
            REG_REPEAT_PERIOD:  cfg_rep  = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input int thr, input int init_ms, input int rep_ms);
        write_reg(REG_AXIS_THRESHOLD, 16'(thr));
        write_reg(REG_INITIAL_DELAY, 16'(init_ms));
        write_reg(REG_REPEAT_PERIOD, 16'(rep_ms));
    endtask

    // wait until every word is taken and every event has come out
    task automatic drain();
        while (pending_words.size() != 0 || i_s_axis_tvalid || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_axis(input int stick, input int axis, input int pos);
        stick_word_t w;
        w.cmd     = CMD_AXIS;
        w.stick   = 2'(stick);
        w.axis    = 1'(axis);
        w.pos     = 8'(pos);
        w.elapsed = 16'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic push_tick(input int elapsed);
        stick_word_t w;
        w.cmd     = CMD_TICK;
        w.stick   = 2'($urandom);
        w.axis    = 1'($urandom);
        w.pos     = 8'($urandom);
        w.elapsed = 16'(elapsed);
        pending_words.push_back(w);
    endtask

    function automatic int strong_pos();
        int t;
        t = cfg_thr;
        if (t == 127 || $urandom_range(1))
            return -(t + 1 + $urandom_range(0, 127 - t));
        return t + 1 + $urandom_range(0, 126 - t);
    endfunction

    function automatic int any_pos();
        int t;
        t = cfg_thr;
        case ($urandom_range(3))
            0: return $urandom_range(0, 255) - 128;
            1: return $urandom_range(1) ? t : -t;
            2: return $urandom_range(1) ? t + 1 : -(t + 1);
            default: return $urandom_range(1) ? 127 : -128;
        endcase
    endfunction

    function automatic int pick_elapsed();
        int r;
        int hi;
        r = $urandom_range(99);
        if (r < 15)
            return 0;
        if (r < 55)
            hi = 2 * cfg_rep + 2;
        else if (r < 80)
            hi = cfg_init + 1;
        else
            hi = 65535;
        if (hi > 65535)
            hi = 65535;
        return $urandom_range(0, hi);
    endfunction

    // mostly press / hold over some ticks / often release, with stray words mixed in
    task automatic add_random(input int count);
        int added;
        int k;
        int ticks;
        int s;
        int a;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99) < 65) begin
                s = $urandom_range(N_STICKS - 1);
                a = $urandom_range(1);
                push_axis(s, a, strong_pos());
                ticks = $urandom_range(1, 5);
                for (k = 0; k < ticks; k++)
                    push_tick(pick_elapsed());
                added += ticks + 1;
                if ($urandom_range(1)) begin
                    push_axis(s, a, $urandom_range(0, 2 * cfg_thr) - cfg_thr);
                    added++;
                end
            end else begin
                if ($urandom_range(1))
                    push_axis($urandom_range(N_STICKS - 1), $urandom_range(1), any_pos());
                else
                    push_tick($urandom_range(0, 65535));
                added++;
            end
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        add_random(count);
        drain();
    endtask

    initial begin : stimulus
        int i;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        errors          = 0;
        axis_words      = 0;
        tick_words      = 0;
        events_checked  = 0;
        most_per_tick   = 0;
        s_word_taken    = 1'b0;
        cfg_thr         = THRESHOLD_RST;
        cfg_init        = INIT_DELAY_RST;
        cfg_rep         = REPEAT_RST;
        for (i = 0; i < N_STICKS; i++) begin
            held_dir[i]  = DIR_NONE;
            time_left[i] = 0;
            repeating[i] = 1'b0;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset settings (threshold 60, delay 500, period 50)
        push_axis(0, AXIS_X, 61);
        push_tick(0);
        push_axis(1, 1, -61);
        push_axis(2, AXIS_X, -128);
        push_axis(3, 1, 127);
        push_axis(0, 1, 100);          // other axis of a held direction: ignored
        push_axis(1, AXIS_X, 90);
        push_tick(16'hFFFF);
        push_tick(0);
        push_axis(1, 1, -60);          // exactly at threshold releases
        push_axis(2, AXIS_X, 60);
        push_axis(3, 1, -61);
        push_tick(1);
        push_axis(1, AXIS_X, 127);
        push_axis(2, 1, -128);
        push_tick(600);
        push_tick(0);
        push_axis(0, AXIS_X, 0);
        push_tick(0);
        push_axis(0, 1, 61);
        push_tick(16'hFFFF);
        push_tick(0);
        push_tick(16'hFFFF);
        push_tick(0);                  // all four sticks due at once
        drain();

        // zero delays: every held direction fires on every tick
        set_regs(0, 0, 0);
        run_phase(0, 0, 57);

        set_regs(127, 16'hFFFF, 16'hFFFF);
        run_phase(74, 0, 57);

        set_regs($urandom_range(1, 126), $urandom_range(0, 400), $urandom_range(0, 120));
        run_phase(0, 74, 57);

        set_regs(THRESHOLD_RST, INIT_DELAY_RST, REPEAT_RST);
        run_phase(10, 10, 57);

        // sender holds off mid phase until every event is out
        set_regs($urandom_range(0, 127), $urandom_range(1, 200), $urandom_range(1, 40));
        run_phase(0, 0, 28);
        run_phase(0, 0, 29);

        $display("covered %0d axis words and %0d ticks, %0d events checked",
                 axis_words, tick_words, events_checked);
        $display("threshold 0..127, delays 0..65535, up to %0d events from one tick",
                 most_per_tick);
        if (errors == 0 && expected_events.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/jda_pkg.sv
rtl/core/jda_front.sv
rtl/core/jda_queue.sv
rtl/core/jda_back.sv
rtl/core/joystick_direction_autorepeat.sv
test/tb_joystick_direction_autorepeat.sv
